// ===== rtl/sbd_pkg.sv =====
// Shared types and constants for the S.BUS frame decoder.
// No dependencies; every rtl file refers to it by scoped names.
package sbd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int NUM_ANALOG  = 16;
  localparam int CHAN_W      = 11;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int PACK_BYTES  = 22;
  localparam int PACK_W      = PACK_BYTES * 8;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] FRAME_CNT  = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0] IDX_HEADER = CNT_W'(0);
  localparam logic [CNT_W-1:0] IDX_FLAGS  = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] IDX_FOOTER = CNT_W'(FRAME_BYTES - 1);

  localparam logic [4:0] CH_DIG0 = 5'(NUM_ANALOG);
  localparam logic [4:0] CH_DIG1 = 5'(NUM_ANALOG + 1);

  localparam logic [7:0] IDLE_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP    = 2'd0;
  localparam logic [1:0] CFG_HEADER = 2'd1;
  localparam logic [1:0] CFG_FOOTER = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] index;
    logic [7:0]       data;
  } byte_cmd_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] footer_value;
  } frame_cfg_t;

  typedef struct packed {
    logic [4:0]        channel_index;
    logic [CHAN_W-1:0] channel_value;
    logic              frame_lost;
    logic              failsafe;
    logic              signal_available;
    logic              last;
  } result_t;

endpackage

// ===== rtl/sbus_frame_decoder.sv =====
// Top level of the S.BUS frame decoder: configuration registers and the
// front end, byte queue and back end. Uses sbd_pkg, sbd_front, sbd_queue, sbd_back.
//
//  channel  ports                                     handshake
//  input    func, data_byte, parity_error            push / full
//  result   channel_index .. last                    empty / pop
//  config   cfg_index, cfg_data                      cfg_we
//
// A byte or tick is accepted whenever the four-entry byte queue has room.
// The back end drains one queued byte per cycle while it is not unpacking; a
// frame that completes with a good header and footer is unpacked into 18 results
// at one per cycle while the result register is free, during which the queue fills
// and then holds off input. The result register is freed by pop in the same cycle
// it is reloaded. Reset is synchronous.
module sbus_frame_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       func,
  input  logic [7:0]                 data_byte,
  input  logic                       parity_error,
  output logic                       empty,
  input  logic                       pop,
  output logic [4:0]                 channel_index,
  output logic [sbd_pkg::CHAN_W-1:0] channel_value,
  output logic                       frame_lost,
  output logic                       failsafe,
  output logic                       signal_available,
  output logic                       last,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data
);

  logic [7:0]          gap_ticks;
  sbd_pkg::frame_cfg_t cfg;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  sbd_pkg::byte_cmd_t  q_cmd;
  sbd_pkg::byte_cmd_t  q_head;
  logic                out_valid;
  sbd_pkg::result_t    out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks        <= 8'd3;
      cfg.header_value <= 8'd15;
      cfg.footer_value <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sbd_pkg::CFG_GAP:    gap_ticks        <= cfg_data;
        sbd_pkg::CFG_HEADER: cfg.header_value <= cfg_data;
        sbd_pkg::CFG_FOOTER: cfg.footer_value <= cfg_data;
        default:             ;
      endcase
    end
  end

  sbd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_full       (q_full),
    .func         (func),
    .data_byte    (data_byte),
    .parity_error (parity_error),
    .gap_ticks    (gap_ticks),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  sbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  sbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .cfg       (cfg),
    .pop       (pop),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign full             = q_full;
  assign empty            = !out_valid;
  assign channel_index    = out_res.channel_index;
  assign channel_value    = out_res.channel_value;
  assign frame_lost       = out_res.frame_lost;
  assign failsafe         = out_res.failsafe;
  assign signal_available = out_res.signal_available;
  assign last             = out_res.last;

endmodule

// ===== rtl/sbd_front.sv =====
// Front end: accepts bytes and ticks, tracks idle time and frame position,
// and forwards good in-frame bytes with their frame index. Uses sbd_pkg.
module sbd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        q_full,
  input  logic                        func,
  input  logic [7:0]                  data_byte,
  input  logic                        parity_error,
  input  logic [7:0]                  gap_ticks,
  output logic                        q_push,
  output sbd_pkg::byte_cmd_t          q_cmd
);

  logic [sbd_pkg::CNT_W-1:0] byte_count;
  logic [sbd_pkg::CNT_W-1:0] byte_count_next;
  logic [7:0]                idle_count;
  logic [7:0]                idle_count_next;
  logic [sbd_pkg::CNT_W-1:0] start;
  logic                      accept;

  assign accept = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      idle_count <= sbd_pkg::IDLE_MAX;
    end else begin
      byte_count <= byte_count_next;
      idle_count <= idle_count_next;
    end
  end

  always_comb begin
    // restart the frame after a long enough idle gap
    start           = (idle_count >= gap_ticks) ? '0 : byte_count;
    byte_count_next = byte_count;
    idle_count_next = idle_count;
    q_push          = 1'b0;
    q_cmd.index     = start;
    q_cmd.data      = data_byte;
    if (accept) begin
      if (func) begin
        if (idle_count != sbd_pkg::IDLE_MAX) begin
          idle_count_next = idle_count + 8'd1;
        end
      end else if (parity_error) begin
        byte_count_next = '0;
      end else begin
        idle_count_next = '0;
        byte_count_next = start;
        // drop bytes past the end of a full frame
        if (start != sbd_pkg::FRAME_CNT) begin
          q_push          = 1'b1;
          byte_count_next = start + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/sbd_queue.sv =====
// Short queue of frame bytes between front end and unpacker.
// Uses sbd_pkg for the entry type and depth.
module sbd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_push,
  input  sbd_pkg::byte_cmd_t q_cmd,
  input  logic               q_pop,
  output logic               q_full,
  output logic               q_empty,
  output sbd_pkg::byte_cmd_t q_head
);

  sbd_pkg::byte_cmd_t          mem [sbd_pkg::QDEPTH];
  logic [sbd_pkg::QPTR_W-1:0]  wr_ptr;
  logic [sbd_pkg::QPTR_W-1:0]  rd_ptr;
  logic [sbd_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign q_full  = (count == sbd_pkg::QCNT_W'(sbd_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign q_head  = mem[rd_ptr];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/sbd_back.sv =====
// Back end: stores frame bytes, checks header and footer, and unpacks the 18
// channels into the result register one per cycle while free. Uses sbd_pkg.
module sbd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  sbd_pkg::byte_cmd_t   q_head,
  input  sbd_pkg::frame_cfg_t  cfg,
  input  logic                 pop,
  output logic                 q_pop,
  output logic                 out_valid,
  output sbd_pkg::result_t     out_res
);

  logic [sbd_pkg::PACK_W-1:0] pack_vec;
  logic [7:0]                 header_byte;
  logic [7:0]                 flag_byte;
  logic                       busy;
  logic [4:0]                 ch;
  logic                       slot_free;
  logic                       emit;
  sbd_pkg::result_t           res;

  assign slot_free = !out_valid || pop;
  assign emit      = busy && slot_free;
  assign q_pop     = !busy && !q_empty;

  always_comb begin
    res.channel_index    = ch;
    res.frame_lost       = flag_byte[2];
    res.failsafe         = flag_byte[3];
    res.signal_available = !(flag_byte[2] || flag_byte[3]);
    res.last             = (ch == sbd_pkg::CH_DIG1);
    if (ch == sbd_pkg::CH_DIG0) begin
      res.channel_value = sbd_pkg::CHAN_W'(flag_byte[0]);
    end else if (ch == sbd_pkg::CH_DIG1) begin
      res.channel_value = sbd_pkg::CHAN_W'(flag_byte[1]);
    end else begin
      res.channel_value = pack_vec[sbd_pkg::CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        case (q_head.index)
          sbd_pkg::IDX_HEADER: header_byte <= q_head.data;
          sbd_pkg::IDX_FLAGS:  flag_byte   <= q_head.data;
          sbd_pkg::IDX_FOOTER: begin
            if (q_head.data == cfg.footer_value && header_byte == cfg.header_value) begin
              busy <= 1'b1;
              ch   <= '0;
            end
          end
          default: begin
            // channel bytes shift in from the top, first byte ends at bit 0
            pack_vec <= {q_head.data, pack_vec[sbd_pkg::PACK_W-1:8]};
          end
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_res   <= res;
        ch        <= ch + 5'd1;
        if (ch < sbd_pkg::CH_DIG0) begin
          pack_vec <= pack_vec >> sbd_pkg::CHAN_W;
        end
        if (ch == sbd_pkg::CH_DIG1) begin
          busy <= 1'b0;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
